// ===== rtl/wcsc_pkg.sv =====
// shared types, codes and constants of the wall column span clipper
package wcsc_pkg;

  localparam int COL_W      = 9;
  localparam int FRAC_W     = 32;
  localparam int CLIP_W     = 12;
  localparam int ROW_W      = 12;
  localparam int VH_W       = 11;
  localparam int FLAGS_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SLOTS      = 4;

  localparam logic [VH_W-1:0] VIEW_HEIGHT_RST = 11'd200;

  // tier_flags bit positions
  localparam int FLAG_MID    = 0;
  localparam int FLAG_TOP    = 1;
  localparam int FLAG_BOTTOM = 2;
  localparam int FLAG_CEIL   = 3;
  localparam int FLAG_FLOOR  = 4;

  // result slot positions, in delivery order
  localparam int SLOT_CEIL  = 0;
  localparam int SLOT_FLOOR = 1;
  localparam int SLOT_UPPER = 2;
  localparam int SLOT_LOWER = 3;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_SEGMENT = 2'd1,
    KIND_STEP    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    WHAT_CEIL   = 3'd0,
    WHAT_FLOOR  = 3'd1,
    WHAT_MID    = 3'd2,
    WHAT_TOP    = 3'd3,
    WHAT_BOTTOM = 3'd4
  } what_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOP_STEP    = 3'd0,
    CFG_BOTTOM_STEP = 3'd1,
    CFG_HIGH_STEP   = 3'd2,
    CFG_LOW_STEP    = 3'd3,
    CFG_TIER_FLAGS  = 3'd4,
    CFG_VIEW_HEIGHT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]               kind;
    logic [COL_W-1:0]         column;
    logic signed [FRAC_W-1:0] top_start;
    logic signed [FRAC_W-1:0] bottom_start;
    logic signed [FRAC_W-1:0] high_start;
    logic signed [FRAC_W-1:0] low_start;
  } in_word_t;

  typedef struct packed {
    logic [2:0]              what;
    logic [COL_W-1:0]        column_res;
    logic signed [ROW_W-1:0] row_low;
    logic signed [ROW_W-1:0] row_high;
    logic                    last;
  } out_word_t;

  typedef struct packed {
    logic signed [FRAC_W-1:0] top_step;
    logic signed [FRAC_W-1:0] bottom_step;
    logic signed [FRAC_W-1:0] high_step;
    logic signed [FRAC_W-1:0] low_step;
    logic [FLAGS_W-1:0]       tier_flags;
    logic [VH_W-1:0]          view_height;
  } cfg_t;

  // one column's work as it enters the compute stage
  typedef struct packed {
    logic [1:0]               kind;
    logic [COL_W-1:0]         column;
    logic signed [FRAC_W-1:0] top;
    logic signed [FRAC_W-1:0] bottom;
    logic signed [FRAC_W-1:0] high;
    logic signed [FRAC_W-1:0] low;
  } col_item_t;

  typedef struct packed {
    logic signed [CLIP_W-1:0] ceil;
    logic signed [CLIP_W-1:0] flo;
  } clip_t;

  typedef struct packed {
    logic [SLOTS-1:0]             mask;
    out_word_t [SLOTS-1:0]        slot;
  } res_set_t;

endpackage

// ===== rtl/wcsc_front.sv =====
// segment state: current column, edge fractions and clip store address
module wcsc_front #(
  parameter int COLUMNS = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  wcsc_pkg::in_word_t  in_word_i,
  input  wcsc_pkg::cfg_t      cfg_i,
  output wcsc_pkg::col_item_t item_o,
  output logic [$clog2(COLUMNS)-1:0] idx_o
);

  localparam int AW = $clog2(COLUMNS);
  localparam int IW = (AW > wcsc_pkg::COL_W) ? AW : wcsc_pkg::COL_W;
  localparam int TW = IW + 1;

  logic [wcsc_pkg::COL_W-1:0]         col_q, col_d;
  logic signed [wcsc_pkg::FRAC_W-1:0] top_q, top_d;
  logic signed [wcsc_pkg::FRAC_W-1:0] bot_q, bot_d;
  logic signed [wcsc_pkg::FRAC_W-1:0] high_q, high_d;
  logic signed [wcsc_pkg::FRAC_W-1:0] low_q, low_d;
  logic                               is_step;
  logic                               is_seg;
  logic                               two_sided;
  logic [TW-1:0]                      rem;

  assign is_step   = (in_word_i.kind == wcsc_pkg::KIND_STEP);
  assign is_seg    = (in_word_i.kind == wcsc_pkg::KIND_SEGMENT);
  assign two_sided = !cfg_i.tier_flags[wcsc_pkg::FLAG_MID];

  always_comb begin
    col_d  = col_q;
    top_d  = top_q;
    bot_d  = bot_q;
    high_d = high_q;
    low_d  = low_q;
    if (accept_i && is_seg) begin
      col_d  = in_word_i.column;
      top_d  = in_word_i.top_start;
      bot_d  = in_word_i.bottom_start;
      high_d = in_word_i.high_start;
      low_d  = in_word_i.low_start;
    end else if (accept_i && is_step) begin
      col_d = col_q + 1'b1;
      top_d = top_q + cfg_i.top_step;
      bot_d = bot_q + cfg_i.bottom_step;
      if (two_sided && cfg_i.tier_flags[wcsc_pkg::FLAG_TOP]) begin
        high_d = high_q + cfg_i.high_step;
      end
      if (two_sided && cfg_i.tier_flags[wcsc_pkg::FLAG_BOTTOM]) begin
        low_d = low_q + cfg_i.low_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      top_q  <= '0;
      bot_q  <= '0;
      high_q <= '0;
      low_q  <= '0;
    end else begin
      col_q  <= col_d;
      top_q  <= top_d;
      bot_q  <= bot_d;
      high_q <= high_d;
      low_q  <= low_d;
    end
  end

  // step items use the segment snapshot, others pass the input column
  always_comb begin
    item_o.kind = in_word_i.kind;
    if (is_step) begin
      item_o.column = col_q;
      item_o.top    = top_q;
      item_o.bottom = bot_q;
      item_o.high   = high_q;
      item_o.low    = low_q;
    end else begin
      item_o.column = in_word_i.column;
      item_o.top    = in_word_i.top_start;
      item_o.bottom = in_word_i.bottom_start;
      item_o.high   = in_word_i.high_start;
      item_o.low    = in_word_i.low_start;
    end
  end

  // column modulo store depth, at most eight subtractions for a 9-bit column
  always_comb begin
    rem = TW'(item_o.column);
    for (int k = 0; k < 8; k++) begin
      if (rem >= TW'(COLUMNS)) begin
        rem = rem - TW'(COLUMNS);
      end
    end
  end

  assign idx_o = rem[AW-1:0];

endmodule

// ===== rtl/wcsc_clip_mem.sv =====
// per-column ceiling and floor clip store with write-to-read bypass
module wcsc_clip_mem #(
  parameter int COLUMNS = 512
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(COLUMNS)-1:0] waddr_i,
  input  wcsc_pkg::clip_t            wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(COLUMNS)-1:0] raddr_i,
  output wcsc_pkg::clip_t            rdata_o
);

  wcsc_pkg::clip_t mem [COLUMNS];
  wcsc_pkg::clip_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/wcsc_column.sv =====
// one column: rounding, clamping against clips, marks, spans and clip update
module wcsc_column #(
  parameter int FRAC_BITS = 12
) (
  input  wcsc_pkg::col_item_t item_i,
  input  wcsc_pkg::cfg_t      cfg_i,
  input  wcsc_pkg::clip_t     clip_i,
  output wcsc_pkg::res_set_t  res_o,
  output logic                wr_req_o,
  output wcsc_pkg::clip_t     wr_data_o
);

  // row values before saturation, with room for the +-1 adjustments
  localparam int RW = 35 - FRAC_BITS;
  localparam logic signed [RW-1:0] ONE    = RW'(1);
  localparam logic signed [RW-1:0] SAT_LO = RW'(-2048);
  localparam logic signed [RW-1:0] SAT_HI = RW'(2047);
  localparam logic signed [32:0]   RND    = 33'((64'(1) << FRAC_BITS) - 64'(1));

  function automatic logic signed [RW-1:0] row_floor(logic signed [31:0] f);
    logic signed [31:0] s;
    s = f >>> FRAC_BITS;
    return RW'(s);
  endfunction

  function automatic logic signed [RW-1:0] row_ceil(logic signed [31:0] f);
    logic signed [32:0] s;
    s = ($signed({f[31], f}) + RND) >>> FRAC_BITS;
    return RW'(s);
  endfunction

  function automatic logic signed [RW-1:0] sat(logic signed [RW-1:0] v);
    logic signed [RW-1:0] r;
    r = v;
    if (v < SAT_LO) r = SAT_LO;
    if (v > SAT_HI) r = SAT_HI;
    return r;
  endfunction

  function automatic wcsc_pkg::out_word_t mk(logic [2:0] what, logic [8:0] col,
                                             logic signed [RW-1:0] lo,
                                             logic signed [RW-1:0] hi);
    wcsc_pkg::out_word_t w;
    w.what       = what;
    w.column_res = col;
    w.row_low    = wcsc_pkg::ROW_W'(lo);
    w.row_high   = wcsc_pkg::ROW_W'(hi);
    w.last       = 1'b0;
    return w;
  endfunction

  logic signed [RW-1:0] cc, fc, yl, yh, bot, top, mh, ml, ncc, nfc;
  logic                 mark_c, mark_f, is_step, is_clear;
  wcsc_pkg::res_set_t   set;

  assign mark_c   = cfg_i.tier_flags[wcsc_pkg::FLAG_CEIL];
  assign mark_f   = cfg_i.tier_flags[wcsc_pkg::FLAG_FLOOR];
  assign is_step  = (item_i.kind == wcsc_pkg::KIND_STEP);
  assign is_clear = (item_i.kind == wcsc_pkg::KIND_CLEAR);

  always_comb begin
    set = '0;
    cc  = RW'(clip_i.ceil);
    fc  = RW'(clip_i.flo);

    // ceiling side
    yl = row_ceil(item_i.top);
    if (yl < cc + ONE) yl = cc + ONE;
    bot = yl - ONE;
    if (bot >= fc) bot = fc - ONE;
    if (mark_c && (cc + ONE <= bot)) begin
      set.mask[wcsc_pkg::SLOT_CEIL] = 1'b1;
      set.slot[wcsc_pkg::SLOT_CEIL] = mk(wcsc_pkg::WHAT_CEIL, item_i.column, cc + ONE, bot);
    end

    // floor side
    yh = row_floor(item_i.bottom);
    if (yh >= fc) yh = fc - ONE;
    top = yh + ONE;
    if (top <= cc) top = cc + ONE;
    if (mark_f && (top <= fc - ONE)) begin
      set.mask[wcsc_pkg::SLOT_FLOOR] = 1'b1;
      set.slot[wcsc_pkg::SLOT_FLOOR] = mk(wcsc_pkg::WHAT_FLOOR, item_i.column, top, fc - ONE);
    end

    ncc = cc;
    nfc = fc;
    mh  = row_floor(item_i.high);
    ml  = row_ceil(item_i.low);
    if (cfg_i.tier_flags[wcsc_pkg::FLAG_MID]) begin
      // solid wall closes the column
      if (yl <= yh) begin
        set.mask[wcsc_pkg::SLOT_UPPER] = 1'b1;
        set.slot[wcsc_pkg::SLOT_UPPER] = mk(wcsc_pkg::WHAT_MID, item_i.column, yl, yh);
      end
      ncc = RW'($signed({1'b0, cfg_i.view_height}));
      nfc = -ONE;
    end else begin
      if (cfg_i.tier_flags[wcsc_pkg::FLAG_TOP]) begin
        if (mh >= fc) mh = fc - ONE;
        if (mh >= yl) begin
          set.mask[wcsc_pkg::SLOT_UPPER] = 1'b1;
          set.slot[wcsc_pkg::SLOT_UPPER] = mk(wcsc_pkg::WHAT_TOP, item_i.column, yl, mh);
          ncc = sat(mh);
        end else begin
          ncc = sat(yl - ONE);
        end
      end else if (mark_c) begin
        ncc = sat(yl - ONE);
      end
      // lower tier clamps against the updated ceiling
      if (cfg_i.tier_flags[wcsc_pkg::FLAG_BOTTOM]) begin
        if (ml <= ncc) ml = ncc + ONE;
        if (ml <= yh) begin
          set.mask[wcsc_pkg::SLOT_LOWER] = 1'b1;
          set.slot[wcsc_pkg::SLOT_LOWER] = mk(wcsc_pkg::WHAT_BOTTOM, item_i.column, ml, yh);
          nfc = sat(ml);
        end else begin
          nfc = sat(yh + ONE);
        end
      end else if (mark_f) begin
        nfc = sat(yh + ONE);
      end
    end

    if (!is_step) set.mask = '0;
  end

  assign res_o    = set;
  assign wr_req_o = is_step || is_clear;

  always_comb begin
    if (is_clear) begin
      wr_data_o.ceil = wcsc_pkg::CLIP_W'(-1);
      wr_data_o.flo  = $signed({1'b0, cfg_i.view_height});
    end else begin
      wr_data_o.ceil = wcsc_pkg::CLIP_W'(sat(ncc));
      wr_data_o.flo  = wcsc_pkg::CLIP_W'(sat(nfc));
    end
  end

endmodule

// ===== rtl/wcsc_out_queue.sv =====
// result register: holds one column's words and sends them one a cycle unless the output stalls
module wcsc_out_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  wcsc_pkg::res_set_t            set_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output wcsc_pkg::out_word_t           out_word_o,
  output logic                          free_o
);

  logic [wcsc_pkg::SLOTS-1:0]      mask_q, mask_d;
  wcsc_pkg::out_word_t [wcsc_pkg::SLOTS-1:0] slot_q;
  logic [wcsc_pkg::SLOTS-1:0]      pick;
  logic [wcsc_pkg::SLOTS-1:0]      rest;
  logic                            take;

  // lowest pending slot goes first
  assign pick        = mask_q & (~mask_q + 1'b1);
  assign rest        = mask_q & ~pick;
  assign out_valid_o = |mask_q;
  assign take        = out_valid_o && !out_stall_i;
  assign free_o      = !out_valid_o || (take && (rest == '0));

  always_comb begin
    out_word_o = '0;
    for (int i = 0; i < wcsc_pkg::SLOTS; i++) begin
      if (pick[i]) out_word_o = slot_q[i];
    end
    out_word_o.last = (rest == '0);
  end

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = set_i.mask;
    end else if (take) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= set_i.slot;
    end
  end

  a_load_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (mask_q == '0) || (take && (rest == '0)))
    else $error("result register loaded while words still pending");

  a_take_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !load_i) |=> ($countones(mask_q) + 1 == $countones($past(mask_q))))
    else $error("taken word not retired");

  a_last_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.last) |-> $onehot(mask_q))
    else $error("last flag with more words pending");

endmodule

// ===== rtl/wall_column_span_clipper.sv =====
// top level of the wall column span clipper
//
// wall column span clipper: keeps a ceiling and a floor clip row for every
// screen column and, for each column step word, sends the ceiling mark, floor
// mark and mid or upper/lower tier spans that survive clipping, then narrows
// the column's clips. an input word is taken every cycle as long as the result
// register can empty in that cycle; a step word that yields several results
// holds the input while its words leave, one result word per cycle while the
// output does not stall, so words with zero or one result run at one per
// cycle. the first result word is offered once the clip store read, taken as
// the word is accepted, has registered and the compute stage has loaded the
// result register, which it does only when that register is free. the clip
// store is one memory of COLUMNS entries with a registered read and a
// write-to-read bypass, read when a word is accepted and written when it
// leaves the compute stage; its contents are undefined until a clear word
// writes a column, so there is no clearing pass after reset.
// configuration is a plain write port and must only be written while idle
module wall_column_span_clipper #(
  parameter int COLUMNS   = 512,
  parameter int FRAC_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  wcsc_pkg::in_word_t                 in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output wcsc_pkg::out_word_t                out_word_o,
  input  logic                               cfg_we_i,
  input  logic [wcsc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wcsc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int AW = $clog2(COLUMNS);

  // configuration registers
  wcsc_pkg::cfg_t cfg_q, cfg_d;

  // front end and compute stage
  wcsc_pkg::col_item_t item_d, s1_item_q;
  logic [AW-1:0]       idx_d, s1_idx_q;
  logic                s1_valid_q, s1_valid_d;
  logic                in_acc;
  logic                s1_adv;
  logic                q_free;

  // clip store and compute results
  wcsc_pkg::clip_t     clip_rd;
  wcsc_pkg::clip_t     clip_wr;
  logic                clip_wr_req;
  logic                clip_we;
  wcsc_pkg::res_set_t  res_set;
  logic                q_load;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        wcsc_pkg::CFG_TOP_STEP:    cfg_d.top_step    = $signed(cfg_data_i);
        wcsc_pkg::CFG_BOTTOM_STEP: cfg_d.bottom_step = $signed(cfg_data_i);
        wcsc_pkg::CFG_HIGH_STEP:   cfg_d.high_step   = $signed(cfg_data_i);
        wcsc_pkg::CFG_LOW_STEP:    cfg_d.low_step    = $signed(cfg_data_i);
        wcsc_pkg::CFG_TIER_FLAGS:  cfg_d.tier_flags  = cfg_data_i[wcsc_pkg::FLAGS_W-1:0];
        wcsc_pkg::CFG_VIEW_HEIGHT: cfg_d.view_height = cfg_data_i[wcsc_pkg::VH_W-1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.top_step    <= '0;
      cfg_q.bottom_step <= '0;
      cfg_q.high_step   <= '0;
      cfg_q.low_step    <= '0;
      cfg_q.tier_flags  <= '0;
      cfg_q.view_height <= wcsc_pkg::VIEW_HEIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // compute stage moves on when the result register can take its words
  assign s1_adv     = !s1_valid_q || q_free;
  assign in_stall_o = !s1_adv;
  assign in_acc     = in_valid_i && s1_adv;

  wcsc_front #(
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_acc),
    .in_word_i (in_word_i),
    .cfg_i     (cfg_q),
    .item_o    (item_d),
    .idx_o     (idx_d)
  );

  assign s1_valid_d = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= item_d;
      s1_idx_q  <= idx_d;
    end
  end

  // clip write lands as the word leaves the compute stage
  assign clip_we = s1_valid_q && q_free && clip_wr_req;
  assign q_load  = s1_valid_q && q_free;

  wcsc_clip_mem #(
    .COLUMNS (COLUMNS)
  ) u_clip_mem (
    .clk_i   (clk_i),
    .we_i    (clip_we),
    .waddr_i (s1_idx_q),
    .wdata_i (clip_wr),
    .re_i    (in_acc),
    .raddr_i (idx_d),
    .rdata_o (clip_rd)
  );

  wcsc_column #(
    .FRAC_BITS (FRAC_BITS)
  ) u_column (
    .item_i    (s1_item_q),
    .cfg_i     (cfg_q),
    .clip_i    (clip_rd),
    .res_o     (res_set),
    .wr_req_o  (clip_wr_req),
    .wr_data_o (clip_wr)
  );

  wcsc_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (q_load),
    .set_i       (res_set),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .free_o      (q_free)
  );

  a_stall_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o))
    else $error("input stalled with nothing in flight");

  a_clip_write_on_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clip_we |-> (s1_valid_q && s1_adv))
    else $error("clip write without compute stage advancing");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted word lost before compute stage");

endmodule
